/* rtl/bdht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdht_pkg
// Shared types, constants and the Bayer rank function of the dot-screen texel
// generator.
// ---------------------------------------------------------------------------
package bdht_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_RESOLUTION = 2'd0;
  localparam logic [1:0] CFG_ORDER_LOG2 = 2'd1;
  localparam logic [1:0] CFG_DOT_COUNT  = 2'd2;
  localparam logic [1:0] CFG_GRADIENT   = 2'd3;

  // round(pi * 2^30)
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam int POS_W  = 28;  // coord << 16 / resolution
  localparam int R2_W   = 30;  // r^2 in Q0.32, below 2^30
  localparam int D2_W   = 57;  // exact squared distance
  localparam int SQ_W   = 56;
  localparam int RANK_W = 9;

  // quadrant offsets of the Bayer recursion
  localparam logic [1:0] QUAD_OFS [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  typedef struct packed {
    logic [12:0] resolution;
    logic [1:0]  order_log2;
    logic [6:0]  dot_count;
    logic        gradient_mode;
  } cfg_t;

  // one item as handed from the front end to the scan engine
  typedef struct packed {
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [R2_W-1:0]   r2;
    logic [1:0]        k;
    logic [RANK_W-1:0] active;
    logic              grad;
  } task_t;

  typedef enum logic {
    F_IDLE,
    F_DIV
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_DIV,
    B_PUT
  } back_state_t;

  // Bayer matrix value of order 2^k at (row, col), k at most 3
  function automatic logic [5:0] bayer_val(input logic [1:0] k,
                                           input logic [2:0] row,
                                           input logic [2:0] col);
    logic [5:0] v;
    logic [1:0] sh;
    logic [1:0] q;
    v  = '0;
    sh = '0;
    q  = '0;
    for (int b = 0; b < 3; b++) begin
      if (2'(b) < k) begin
        sh = k - 2'd1 - 2'(b);
        q  = QUAD_OFS[{row[sh], col[sh]}];
        v  = v + (6'(q) << (2 * b));
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/bdht_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdht_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bdht_div #(
  parameter int NW = 28,
  parameter int DW = 13,
  parameter int QW = 28
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [QW-1:0]      quo
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, num_r[NW-1]};
    diff    = trial - {1'b0, den_r};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

/* rtl/bdht_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdht_front
// Takes an item, clamps the configuration and runs the position and radius
// divisions in parallel, then hands the prepared task to the queue.
// ---------------------------------------------------------------------------
module bdht_front import bdht_pkg::*; #(
  parameter int MAX_ORDER      = 8,
  parameter int MAX_RESOLUTION = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_pixel_y,
  output logic             push,
  output task_t            push_data,
  input  wire logic        q_full
);

  localparam int KLOG = $clog2(MAX_ORDER + 1) - 1;
  localparam int KMAX = (KLOG > 3) ? 3 : KLOG;
  localparam logic [61:0] R2_NUM = {1'b1, 61'b0};

  front_state_t state_r;
  front_state_t state_nxt;

  logic [12:0]      res_eff;
  logic [1:0]       k_eff;
  logic [38:0]      r2_den;
  logic             start;
  logic             all_idle;
  logic             busy_x;
  logic             busy_y;
  logic             busy_r2;
  logic [POS_W-1:0] quo_x;
  logic [POS_W-1:0] quo_y;
  logic [R2_W-1:0]  quo_r2;

  always_comb begin
    if (cfg.resolution == '0) begin
      res_eff = 13'd1;
    end else if ({4'b0, cfg.resolution} > 17'(MAX_RESOLUTION)) begin
      res_eff = 13'(MAX_RESOLUTION);
    end else begin
      res_eff = cfg.resolution;
    end
    k_eff = (cfg.order_log2 == '0) ? 2'd1 : cfg.order_log2;
    if (k_eff > 2'(KMAX)) begin
      k_eff = 2'(KMAX);
    end
    // r^2 = 2^62 / (2 * pi_q30 * dots) = 2^61 / (pi_q30 * dots)
    r2_den = {7'b0, PI_Q30} * {32'b0, cfg.dot_count};
  end

  assign all_idle = !busy_x && !busy_y && !busy_r2;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (all_idle && !q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    push     = 1'b0;
    case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_DIV:   push     = all_idle && !q_full;
      default: begin
        in_ready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  assign start = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  bdht_div #(.NW(POS_W), .DW(13), .QW(POS_W)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   ({in_pixel_x, 16'b0}),
    .den   (res_eff),
    .busy  (busy_x),
    .quo   (quo_x)
  );

  bdht_div #(.NW(POS_W), .DW(13), .QW(POS_W)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   ({in_pixel_y, 16'b0}),
    .den   (res_eff),
    .busy  (busy_y),
    .quo   (quo_y)
  );

  bdht_div #(.NW(62), .DW(39), .QW(R2_W)) u_div_r2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (R2_NUM),
    .den   (r2_den),
    .busy  (busy_r2),
    .quo   (quo_r2)
  );

  always_comb begin
    push_data.px     = quo_x;
    push_data.py     = quo_y;
    // no dots: radius forced to zero so nothing can hit
    push_data.r2     = (cfg.dot_count == '0) ? '0 : quo_r2;
    push_data.k      = k_eff;
    push_data.active = {cfg.dot_count, 2'b00};
    push_data.grad   = cfg.gradient_mode;
  end

endmodule
`default_nettype wire

/* rtl/bdht_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdht_queue
// Two-entry task queue between the front end and the scan engine.
// ---------------------------------------------------------------------------
module bdht_queue import bdht_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire task_t push_data,
  output logic       full,
  input  wire logic  pop,
  output task_t      pop_data,
  output logic       empty
);

  task_t      mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bdht_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bdht_back
// Scan engine: walks the 2n x 2n dot grid one cell a cycle through a
// three-stage distance pipe, keeps the minimum squared distance of the active
// dots and turns it into the texel value.
// ---------------------------------------------------------------------------
module bdht_back import bdht_pkg::*; #(
  parameter int MAX_ORDER = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire task_t  q_data,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [15:0] out_intensity
);

  localparam int KLOG = $clog2(MAX_ORDER + 1) - 1;
  localparam int KMAX = (KLOG > 3) ? 3 : KLOG;
  localparam int RW   = KMAX + 1;

  back_state_t state_r;
  back_state_t state_nxt;

  task_t             task_r;
  logic [RW-1:0]     row_r;
  logic [RW-1:0]     col_r;
  logic [D2_W-1:0]   dmin_r;
  logic              v1_r;
  logic [POS_W-1:0]  adx_r;
  logic [POS_W-1:0]  ady_r;
  logic              v2_r;
  logic [SQ_W-1:0]   sqx_r;
  logic [SQ_W-1:0]   sqy_r;
  logic [15:0]       res_r;
  logic              out_valid_r;
  logic [15:0]       out_int_r;

  logic [RW-1:0]     mask;
  logic [RW-1:0]     rr;
  logic [RW-1:0]     cc;
  logic [5:0]        bv;
  logic [RANK_W-1:0] rank;
  logic              act_ok;
  logic [3:0]        shamt;
  logic [RW:0]       cpos;
  logic [RW:0]       rpos;
  logic [16:0]       cx;
  logic [16:0]       cy;
  logic [POS_W:0]    dxs;
  logic [POS_W:0]    dys;
  logic [POS_W:0]    ndx;
  logic [POS_W:0]    ndy;
  logic [D2_W-1:0]   d2;
  logic              last_cell;
  logic              pipe_empty;
  logic              hit;
  logic              out_free;
  logic              issue;
  logic              div_start;
  logic              div_busy;
  logic              out_load;
  logic [R2_W-1:0]   r2_gap;
  logic [16:0]       div_quo;

  // grid walk and distance of the cell being issued
  always_comb begin
    mask      = RW'((32'd2 << task_r.k) - 32'd1);
    rr        = (row_r + 1'b1) & mask;
    cc        = (col_r + 1'b1) & mask;
    bv        = bayer_val(task_r.k, 3'(rr >> 1), 3'(cc >> 1));
    rank      = {1'b0, bv, 2'b00} + RANK_W'(1) + {{(RANK_W-2){1'b0}}, rr[0], cc[0]};
    act_ok    = rank <= task_r.active;
    shamt     = 4'd15 - {2'b0, task_r.k};
    // dot centres sit on even cell corners
    cpos      = {1'b0, col_r} + {{RW{1'b0}}, col_r[0]};
    rpos      = {1'b0, row_r} + {{RW{1'b0}}, row_r[0]};
    cx        = 17'(cpos) << shamt;
    cy        = 17'(rpos) << shamt;
    dxs       = {{(POS_W-16){1'b0}}, cx} - {1'b0, task_r.px};
    dys       = {{(POS_W-16){1'b0}}, cy} - {1'b0, task_r.py};
    ndx       = -dxs;
    ndy       = -dys;
    last_cell = (row_r == mask) && (col_r == mask);
    d2        = {1'b0, sqx_r} + {1'b0, sqy_r};
    pipe_empty = !v1_r && !v2_r;
    hit       = dmin_r < {{(D2_W-R2_W){1'b0}}, task_r.r2};
    r2_gap    = task_r.r2 - dmin_r[R2_W-1:0];
    out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (last_cell) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = (task_r.grad && hit) ? B_DIV : B_PUT;
        end
      end
      B_DIV: begin
        if (!div_busy) begin
          state_nxt = B_PUT;
        end
      end
      B_PUT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      B_IDLE:  pop       = !q_empty;
      B_SCAN:  issue     = 1'b1;
      B_DRAIN: div_start = pipe_empty && task_r.grad && hit;
      B_PUT:   out_load  = out_free;
      default: begin
        pop       = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue && act_ok;
      v2_r    <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      task_r <= q_data;
      row_r  <= '0;
      col_r  <= '0;
    end else if (issue) begin
      if (col_r == mask) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    adx_r <= dxs[POS_W] ? ndx[POS_W-1:0] : dxs[POS_W-1:0];
    ady_r <= dys[POS_W] ? ndy[POS_W-1:0] : dys[POS_W-1:0];
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
    if (pop) begin
      dmin_r <= '1;
    end else if (v2_r && (d2 < dmin_r)) begin
      dmin_r <= d2;
    end
    if (state_r == B_DRAIN && pipe_empty) begin
      res_r <= (!task_r.grad && hit) ? 16'hFFFF : 16'h0000;
    end else if (state_r == B_DIV && !div_busy) begin
      res_r <= div_quo[16] ? 16'hFFFF : div_quo[15:0];
    end
    if (out_load) begin
      out_int_r <= res_r;
    end
  end

  // (r^2 - dmin) * 65536 / r^2 of the nearest active dot
  bdht_div #(.NW(R2_W + 16), .DW(R2_W), .QW(17)) u_div_grad (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({r2_gap, 16'b0}),
    .den   (task_r.r2),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign out_valid     = out_valid_r;
  assign out_intensity = out_int_r;

endmodule
`default_nettype wire

/* rtl/bayer_dot_halftone_texel_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bayer_dot_halftone_texel_top
// Halftone dot-screen texel generator: pixel coordinate in, Q0.16 intensity
// out, built on an ordered-dither Bayer dot ranking.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid/in_ready   | in_pixel_x[11:0], in_pixel_y[11:0]
//  out     | out_valid/out_ready | out_intensity[15:0]
//  cfg     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[12:0]
//
//  Front end: each item is accepted, run through the 62-step radius divider
//  and the position dividers, then pushed; it takes no new item before that.
//  Scan engine: 4n^2 grid cells at one cell a cycle, then the distance pipe
//  drains and the gradient divider runs when a dot is hit in gradient mode.
//  Front end and scan engine overlap on different items; 2 tasks can queue.
//  Reset is synchronous; cfg_ready is always high.
// ---------------------------------------------------------------------------
module bayer_dot_halftone_texel_top import bdht_pkg::*; #(
  parameter int MAX_ORDER      = 8,
  parameter int MAX_RESOLUTION = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_intensity,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  cfg_t  cfg_r;
  logic  push;
  task_t push_data;
  logic  q_full;
  logic  pop;
  task_t pop_data;
  logic  q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resolution    <= 13'd256;
      cfg_r.order_log2    <= 2'd1;
      cfg_r.dot_count     <= 7'd1;
      cfg_r.gradient_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESOLUTION: cfg_r.resolution    <= cfg_data;
        CFG_ORDER_LOG2: cfg_r.order_log2    <= cfg_data[1:0];
        CFG_DOT_COUNT:  cfg_r.dot_count     <= cfg_data[6:0];
        CFG_GRADIENT:   cfg_r.gradient_mode <= cfg_data[0];
        default:        cfg_r               <= cfg_r;
      endcase
    end
  end

  bdht_front #(
    .MAX_ORDER      (MAX_ORDER),
    .MAX_RESOLUTION (MAX_RESOLUTION)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  bdht_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  bdht_back #(
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_intensity (out_intensity)
  );

endmodule
`default_nettype wire

/* sim/texel_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// texel_checker
// Watches the pixel, intensity and register channels of the halftone texel
// generator. Keeps its own copy of the screen registers, predicts the
// intensity of every accepted pixel and compares results in arrival order.
// ---------------------------------------------------------------------------
module texel_checker import bdht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_intensity,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          mismatches,
  output int          pending_texels
);

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  localparam u64_t        PI_Q30_FIX = 64'd3373259426;  // round(pi * 2^30)
  localparam int unsigned RES_LIMIT  = 4096;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] intensity;
  } texel_expect_t;

  logic [12:0]   screen_res;
  logic [1:0]    screen_order;
  logic [6:0]    screen_dots;
  logic          screen_grad;
  texel_expect_t expected_texels [$];

  function automatic logic [15:0] predict_texel(input logic [11:0] xc,
                                                input logic [11:0] yc);
    u64_t        res, px, py, r2, d2, v, best;
    s64_t        dx, dy;
    int unsigned k, side, cell_w, rr, cc, bv, rank, active, r, c, b, yb, xb;
    bit          hit;
    best = 0;
    hit  = 1'b0;
    r2   = 0;
    res  = screen_res;
    if (res == 0) res = 1;
    if (res > RES_LIMIT) res = RES_LIMIT;
    // a 2-bit order never gets past n = 8
    k      = (screen_order == 0) ? 1 : screen_order;
    side   = 2 << k;
    cell_w = 65536 >> (k + 1);
    px     = (u64_t'(xc) << 16) / res;
    py     = (u64_t'(yc) << 16) / res;
    active = 4 * screen_dots;
    if (screen_dots != 0) r2 = (u64_t'(1) << 62) / (2 * PI_Q30_FIX * screen_dots);
    for (r = 0; r < side; r++) begin
      rr = (r + 1) & (side - 1);
      for (c = 0; c < side; c++) begin
        cc = (c + 1) & (side - 1);
        bv = 0;
        for (b = 0; b < k; b++) begin
          yb = ((rr >> 1) >> (k - 1 - b)) & 1;
          xb = ((cc >> 1) >> (k - 1 - b)) & 1;
          // quadrant order 0,2,3,1
          bv += (2 * (xb ^ yb) + yb) << (2 * b);
        end
        rank = 4 * bv + 1 + 2 * (rr & 1) + (cc & 1);
        if (rank <= active) begin
          dx = s64_t'(cell_w) * s64_t'(c + (c & 1)) - s64_t'(px);
          dy = s64_t'(cell_w) * s64_t'(r + (r & 1)) - s64_t'(py);
          d2 = u64_t'(dx * dx + dy * dy);
          if (d2 < r2) begin
            v   = ((r2 - d2) << 16) / r2;
            hit = 1'b1;
            if (v > best) best = v;
          end
        end
      end
    end
    if (screen_grad) return (best > 65535) ? 16'hFFFF : best[15:0];
    return hit ? 16'hFFFF : 16'h0000;
  endfunction

  always @(posedge clk) begin
    texel_expect_t head;
    if (!rst_n) begin
      screen_res   = 13'd256;
      screen_order = 2'd1;
      screen_dots  = 7'd1;
      screen_grad  = 1'b0;
      expected_texels.delete();
      mismatches     <= 0;
      pending_texels <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESOLUTION: screen_res   = cfg_data;
          CFG_ORDER_LOG2: screen_order = cfg_data[1:0];
          CFG_DOT_COUNT:  screen_dots  = cfg_data[6:0];
          CFG_GRADIENT:   screen_grad  = cfg_data[0];
          default: ;
        endcase
      end
      // retire first: a result never belongs to a pixel taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_texels.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] intensity %0d arrived with no pixel pending", $realtime,
                     out_intensity);
          mismatches <= mismatches + 1;
        end else begin
          head = expected_texels.pop_front();
          if (head.intensity !== out_intensity) begin
            if (mismatches < 10)
              $display("[%0t] pixel (%0d,%0d): intensity expected %0d, got %0d",
                       $realtime, head.x, head.y, head.intensity, out_intensity);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_texels.push_back('{x: in_pixel_x, y: in_pixel_y,
                                    intensity: predict_texel(in_pixel_x, in_pixel_y)});
      pending_texels <= expected_texels.size();
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives pixel coordinates and screen register writes into the halftone texel
// generator with random gaps and stalls; texel_checker predicts and compares.
// ---------------------------------------------------------------------------
module testbench;
  import bdht_pkg::*;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic [11:0] in_pixel_x    = '0;
  logic [11:0] in_pixel_y    = '0;
  logic        out_ready     = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic [1:0]  cfg_index     = '0;
  logic [12:0] cfg_data      = '0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] out_intensity;
  logic        cfg_ready;
  int          mismatches;
  int          pending_texels;

  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;
  bit hold_pending = 1'b0;
  int pixels_sent  = 0;
  int screens_used = 1;  // reset values count as the first screen

  bayer_dot_halftone_texel_top i_dut (.*);
  texel_checker i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL bayer_dot_halftone_texel_top");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : intensity_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pending) begin
        stall        = 800;
        hold_pending = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_pixel(input int x, input int y);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= 12'(x);
    in_pixel_y <= 12'(y);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_texels != 0) @(posedge clk);
  endtask

  // narrow registers get random upper data bits, which the block must drop
  task automatic load_screen(input logic [12:0] res, input logic [1:0] ord,
                             input logic [6:0] dots, input logic grad);
    logic [1:0]  idx   [4];
    logic [12:0] words [4];
    idx[0]   = CFG_RESOLUTION;
    words[0] = res;
    idx[1]   = CFG_ORDER_LOG2;
    words[1] = {11'($urandom), ord};
    idx[2]   = CFG_DOT_COUNT;
    words[2] = {6'($urandom), dots};
    idx[3]   = CFG_GRADIENT;
    words[3] = {12'($urandom), grad};
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    screens_used++;
  endtask

  initial begin : pixel_source
    logic [12:0] res;
    logic [6:0]  dots;
    int          eff_res;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset screen, coordinates past the resolution included
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(128, 128);
    send_pixel(64, 192);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    // zero resolution, zero order, no dots
    load_screen(13'd0, 2'd0, 7'd0, 1'b1);
    send_pixel(0, 0);
    send_pixel(2048, 1024);
    // resolution clamped to the maximum, largest order, most dots
    load_screen(13'h1FFF, 2'd3, 7'd127, 1'b1);
    send_pixel(0, 0);
    send_pixel(1024, 2048);
    send_pixel(4095, 4095);
    load_screen(13'd4096, 2'd2, 7'd64, 1'b0);
    send_pixel(512, 512);
    send_pixel(1000, 3000);
    send_pixel(4095, 4095);
    // one-pixel texture: every coordinate but zero lies outside
    load_screen(13'd1, 2'd1, 7'd1, 1'b1);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(4095, 2);
    load_screen(13'd16, 2'd3, 7'd2, 1'b1);
    send_pixel(4, 4);
    send_pixel(8, 0);
    send_pixel(2, 14);
    send_pixel(15, 15);

    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0:       res = 13'd256;
        1:       res = 13'd4096;
        2:       res = 13'($urandom_range(2, 64));
        3:       res = 13'($urandom_range(1, 8191));
        4:       res = 13'd1000;
        default: res = 13'($urandom_range(100, 4096));
      endcase
      case (p % 8)
        0:       dots = 7'd1;
        1:       dots = 7'd64;
        2:       dots = 7'($urandom_range(2, 16));
        3:       dots = 7'd127;
        4:       dots = 7'd0;
        5:       dots = 7'($urandom_range(1, 64));
        6:       dots = 7'd65;
        default: dots = 7'($urandom_range(1, 127));
      endcase
      load_screen(res, 2'(p % 4), dots, 1'((p / 3) % 2));
      eff_res = (res == 0) ? 1 : (res > 4096) ? 4096 : res;
      for (int i = 0; i < 102; i++) begin
        tx_quiet = ((i / 25) % 4 == 3);
        rx_quiet = tx_quiet;
        if (p == 2 && i == 30) hold_pending = 1'b1;
        if (p == 3 && i == 50) drain_results();
        if ($urandom_range(0, 7) == 0)
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          send_pixel($urandom_range(0, eff_res - 1), $urandom_range(0, eff_res - 1));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Ran %0d pixels over %0d screen settings (binary and gradient, orders 2..8,",
             pixels_sent, screens_used);
    $display("clamped resolutions and dot counts) with stalls and a long result hold-off.");
    if (mismatches == 0) begin
      $display("PASS bayer_dot_halftone_texel_top");
    end else begin
      $display("FAIL bayer_dot_halftone_texel_top");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bdht_pkg.sv
rtl/bdht_div.sv
rtl/bdht_front.sv
rtl/bdht_queue.sv
rtl/bdht_back.sv
rtl/bayer_dot_halftone_texel_top.sv
sim/texel_checker.sv
sim/testbench.sv
